FILE: rtl/first_fit_block_allocator_defines.svh
// Assertion macros for the first-fit block allocator.
// Included by the top level; depends on nothing else.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define FFBA_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent, outside reset.
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ffba_pkg.sv
// Package for the first-fit block allocator: state codes, status codes and request kinds.
// Used by the top level; depends on nothing.
package ffba_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;

  // Request kinds.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SHIFT_UP,
    S_SPLIT,
    S_MERGE_NEXT,
    S_MERGE_PREV,
    S_SHIFT_DN,
    S_DONE
  } state_t;

endpackage

FILE: rtl/ffba_if.sv
// Valid/ready channel interfaces for the allocator's requests and results.
// Depends on nothing; widths follow the request and result fields.
interface ffba_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [12:0] req_size;
  logic [12:0] req_offset;
  modport source (output valid, op, req_size, req_offset, input ready);
  modport sink   (input valid, op, req_size, req_offset, output ready);
endinterface

interface ffba_rsp_if;
  logic        valid;
  logic        ready;
  logic [11:0] grant_offset;
  logic [1:0]  status;
  modport source (output valid, grant_offset, status, input ready);
  modport sink   (input valid, grant_offset, status, output ready);
endinterface

FILE: rtl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator with full coalescing.
// Depends on ffba_pkg, ffba_if.sv and first_fit_block_allocator_defines.svh.
//
//  channel  | kind     | payload
//  req      | sink     | op, req_size, req_offset
//  rsp      | source   | grant_offset, status
//  cfg      | write    | cfg_wdata (arena size), cfg_we
//
// A request walks the block table one entry per cycle through a single
// registered memory read port; a split or merge then moves table entries at
// one per cycle. Reset or an arena write rebuilds one free block.
// Ready is low while a request is in progress or an arena write is made;
// a finished result waits only if the previous one is still held in the
// output register.
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  ffba_req_if.sink    req,
  ffba_rsp_if.source  rsp
);
  `include "first_fit_block_allocator_defines.svh"

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [12:0] HDR = 13'd24;

  // Table memory: start, payload and free mark packed in one word.
  logic [25:0] mem [MAX_BLOCKS];
  logic [25:0] rd_q;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [25:0] wr_data;
  logic wr_en;

  ffba_pkg::state_t state, state_next;
  logic [CW-1:0] total, total_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] jdx, jdx_next;
  logic [12:0] arena, arena_next;
  logic        op_q;
  logic [12:0] offs;
  logic [13:0] need, need_next;
  logic [25:0] cur, cur_next;
  logic [25:0] prv, prv_next;
  logic        last_pass, last_pass_next;
  logic [11:0] res_grant, res_grant_next;
  logic [1:0]  res_stat, res_stat_next;
  logic [11:0] grant, grant_next;
  logic [1:0]  stat, stat_next;
  logic        out_v, out_v_next;

  logic [12:0] lim;
  logic [12:0] rd_start, rd_pay;
  logic        rd_free;
  logic [13:0] fit_min;

  assign rd_start = {1'b0, rd_q[25:14]};
  assign rd_pay   = rd_q[13:1];
  assign rd_free  = rd_q[0];
  assign fit_min  = need + 14'd24;

  always_comb begin
    lim = cfg_wdata;
    if (lim < 13'd32) lim = 13'd32;
    if (lim > 13'd4096) lim = 13'd4096;
  end

  // Memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffba_pkg::S_CLEAR;
      total <= CW'(1);
      arena <= 13'd4096;
      out_v <= 1'b0;
      idx   <= '0;
      jdx   <= '0;
    end else begin
      state <= state_next;
      total <= total_next;
      arena <= arena_next;
      out_v <= out_v_next;
      idx   <= idx_next;
      jdx   <= jdx_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    need      <= need_next;
    cur       <= cur_next;
    prv       <= prv_next;
    last_pass <= last_pass_next;
    res_grant <= res_grant_next;
    res_stat  <= res_stat_next;
    grant     <= grant_next;
    stat      <= stat_next;
    if (req.valid && req.ready) begin
      op_q <= req.op;
      offs <= req.req_offset;
    end
  end

  assign req.ready = (state == ffba_pkg::S_IDLE) && !cfg_we;
  assign rsp.valid = out_v;
  assign rsp.grant_offset = grant;
  assign rsp.status = stat;

  // Sequencer.
  always_comb begin
    state_next     = state;
    total_next     = total;
    arena_next     = arena;
    idx_next       = idx;
    jdx_next       = jdx;
    need_next      = need;
    cur_next       = cur;
    prv_next       = prv;
    last_pass_next = last_pass;
    res_grant_next = res_grant;
    res_stat_next  = res_stat;
    grant_next     = grant;
    stat_next      = stat;
    out_v_next     = out_v && !rsp.ready;
    rd_addr        = idx[IW-1:0];
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    case (state)
      ffba_pkg::S_CLEAR: begin
        wr_en      = 1'b1;
        wr_data    = {12'd0, arena - HDR, 1'b1};
        total_next = CW'(1);
        state_next = ffba_pkg::S_IDLE;
      end
      ffba_pkg::S_IDLE: begin
        if (req.valid && req.ready) begin
          need_next  = ({1'b0, req.req_size} + 14'd7) & ~14'd7;
          idx_next   = '0;
          rd_addr    = '0;
          state_next = ffba_pkg::S_CHECK;
        end
      end
      // Entry idx is in rd_q; one entry is examined per cycle.
      ffba_pkg::S_CHECK: begin
        if (op_q == ffba_pkg::OP_FREE) begin
          if (rd_start + HDR == offs) begin
            cur_next       = {rd_q[25:1], 1'b1};
            wr_en          = 1'b1;
            wr_addr        = idx[IW-1:0];
            wr_data        = {rd_q[25:1], 1'b1};
            rd_addr        = IW'(idx + CW'(1));
            res_grant_next = '0;
            res_stat_next  = ffba_pkg::ST_OK;
            state_next     = ffba_pkg::S_MERGE_NEXT;
          end else if (idx + CW'(1) >= total) begin
            res_grant_next = '0;
            res_stat_next  = ffba_pkg::ST_INVALID;
            state_next     = ffba_pkg::S_DONE;
          end else begin
            idx_next = idx + CW'(1);
            prv_next = rd_q;
            rd_addr  = IW'(idx + CW'(1));
          end
        end else if (rd_free && {1'b0, rd_pay} == need) begin
          wr_en          = 1'b1;
          wr_addr        = idx[IW-1:0];
          wr_data        = {rd_q[25:1], 1'b0};
          res_grant_next = rd_q[25:14] + 12'd24;
          res_stat_next  = ffba_pkg::ST_OK;
          state_next     = ffba_pkg::S_DONE;
        end else if (rd_free && {1'b0, rd_pay} >= fit_min) begin
          res_grant_next = rd_q[25:14] + 12'd24;
          res_stat_next  = ffba_pkg::ST_OK;
          wr_en          = 1'b1;
          wr_addr        = idx[IW-1:0];
          // A remainder of only a header, or a full table, keeps the block whole.
          if ({1'b0, rd_pay} == fit_min || total >= CW'(MAX_BLOCKS)) begin
            wr_data    = {rd_q[25:1], 1'b0};
            state_next = ffba_pkg::S_DONE;
          end else begin
            wr_data    = {rd_q[25:14], need[12:0], 1'b0};
            cur_next   = rd_q;
            jdx_next   = total;
            rd_addr    = IW'(total - CW'(1));
            state_next = ffba_pkg::S_SHIFT_UP;
          end
        end else if (idx + CW'(1) >= total) begin
          res_grant_next = '0;
          res_stat_next  = ffba_pkg::ST_NO_SPACE;
          state_next     = ffba_pkg::S_DONE;
        end else begin
          idx_next = idx + CW'(1);
          prv_next = rd_q;
          rd_addr  = IW'(idx + CW'(1));
        end
      end
      // Move entries idx+1..total-1 up by one, from the top down.
      ffba_pkg::S_SHIFT_UP: begin
        if (jdx > idx + CW'(1)) begin
          wr_en    = 1'b1;
          wr_addr  = jdx[IW-1:0];
          wr_data  = rd_q;
          jdx_next = jdx - CW'(1);
          rd_addr  = IW'(jdx - CW'(2));
        end else begin
          state_next = ffba_pkg::S_SPLIT;
        end
      end
      // Write the free remainder just above the granted block.
      ffba_pkg::S_SPLIT: begin
        wr_en      = 1'b1;
        wr_addr    = IW'(idx + CW'(1));
        wr_data    = {cur[25:14] + need[11:0] + 12'd24,
                      cur[13:1] - need[12:0] - HDR, 1'b1};
        total_next = total + CW'(1);
        state_next = ffba_pkg::S_DONE;
      end
      // Entry idx+1 is in rd_q; absorb it when it is free.
      ffba_pkg::S_MERGE_NEXT: begin
        if (idx + CW'(1) < total && rd_free) begin
          cur_next       = {cur[25:14], cur[13:1] + rd_pay + HDR, 1'b1};
          wr_en          = 1'b1;
          wr_addr        = idx[IW-1:0];
          wr_data        = {cur[25:14], cur[13:1] + rd_pay + HDR, 1'b1};
          jdx_next       = idx + CW'(1);
          rd_addr        = IW'(idx + CW'(2));
          last_pass_next = 1'b0;
          state_next     = ffba_pkg::S_SHIFT_DN;
        end else begin
          state_next = ffba_pkg::S_MERGE_PREV;
        end
      end
      // The freed block joins the entry below it when that one is free.
      ffba_pkg::S_MERGE_PREV: begin
        if (idx != CW'(0) && prv[0]) begin
          wr_en          = 1'b1;
          wr_addr        = IW'(idx - CW'(1));
          wr_data        = {prv[25:14], prv[13:1] + cur[13:1] + HDR, 1'b1};
          jdx_next       = idx;
          rd_addr        = IW'(idx + CW'(1));
          last_pass_next = 1'b1;
          state_next     = ffba_pkg::S_SHIFT_DN;
        end else begin
          state_next = ffba_pkg::S_DONE;
        end
      end
      // Close the hole at jdx; rd_q holds entry jdx+1.
      ffba_pkg::S_SHIFT_DN: begin
        if (jdx + CW'(1) < total) begin
          wr_en    = 1'b1;
          wr_addr  = jdx[IW-1:0];
          wr_data  = rd_q;
          jdx_next = jdx + CW'(1);
          rd_addr  = IW'(jdx + CW'(2));
        end else begin
          total_next = total - CW'(1);
          state_next = last_pass ? ffba_pkg::S_DONE : ffba_pkg::S_MERGE_PREV;
        end
      end
      // Hand the result to the output register once it is free.
      ffba_pkg::S_DONE: begin
        if (!out_v_next) begin
          out_v_next = 1'b1;
          grant_next = res_grant;
          stat_next  = res_stat;
          state_next = ffba_pkg::S_IDLE;
        end
      end
      default: state_next = ffba_pkg::S_IDLE;
    endcase
    // An arena write rebuilds the table.
    if (cfg_we) begin
      arena_next = lim;
      state_next = ffba_pkg::S_CLEAR;
    end
  end

  // Assertions.
  `FFBA_ASSERT(a_total_range, 1'b1, total >= CW'(1) && total <= CW'(MAX_BLOCKS),
               "block count out of range")
  `FFBA_ASSERT(a_busy_not_ready, state != ffba_pkg::S_IDLE, !req.ready,
               "ready while busy")
  `FFBA_ASSERT_NEXT(a_result_held, out_v && !rsp.ready,
                    out_v && $stable(grant) && $stable(stat),
                    "result changed while waiting")
  `FFBA_ASSERT(a_bad_grant, out_v && stat != ffba_pkg::ST_OK, grant == 12'd0,
               "grant not zero on failure")

endmodule
